// File: rtl/jsu_pkg.sv
package jsu_pkg;

    localparam int unsigned QDEPTH_DEF = 4;

    // Bytes seen after a backslash
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LC_B   = 8'h62;
    localparam logic [7:0] CH_LC_F   = 8'h66;
    localparam logic [7:0] CH_LC_N   = 8'h6E;
    localparam logic [7:0] CH_LC_R   = 8'h72;
    localparam logic [7:0] CH_LC_T   = 8'h74;
    localparam logic [7:0] CH_LC_U   = 8'h75;

    // Control characters they stand for
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_FF  = 8'h0C;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_TAB = 8'h09;

    typedef enum logic [2:0] {
        MODE_TEXT = 3'd0,
        MODE_ESC  = 3'd1,
        MODE_HEX0 = 3'd2,
        MODE_HEX1 = 3'd3,
        MODE_HEX2 = 3'd4,
        MODE_HEX3 = 3'd5
    } t_mode;

    // One queued command: a single result, or a backslash followed by data
    typedef struct packed {
        logic       pair;
        logic [7:0] data;
        logic       last;
        logic       error;
    } t_cmd;

    // {bad, digit}: bad set when the byte is not 0-9, a-f or A-F
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [7:0] t;
        begin
            t = 8'h00;
            if (c >= 8'h30 && c <= 8'h39) begin
                t = c - 8'h30;
                hex_value = {1'b0, t[3:0]};
            end else if (c >= 8'h61 && c <= 8'h66) begin
                t = c - 8'h57;
                hex_value = {1'b0, t[3:0]};
            end else if (c >= 8'h41 && c <= 8'h46) begin
                t = c - 8'h37;
                hex_value = {1'b0, t[3:0]};
            end else begin
                hex_value = 5'b1_0000;
            end
        end
    endfunction

endpackage

// File: rtl/jsu_front.sv
module jsu_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [7:0]    i_byte,
    input  logic          i_last,
    input  logic          i_q_ready,
    output logic          o_ready,
    output logic          o_push,
    output jsu_pkg::t_cmd o_cmd
);
    import jsu_pkg::*;

    t_mode      r_mode, n_mode;
    logic [7:0] r_code, n_code;
    logic       r_bad, n_bad;
    logic       accept;
    logic [4:0] hv;
    logic       hv_bad;
    logic [7:0] code_upd;

    assign accept   = i_valid && i_q_ready;
    assign o_ready  = i_q_ready;
    assign hv       = hex_value(i_byte);
    assign hv_bad   = hv[4];
    assign code_upd = {r_code[3:0], hv[3:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_TEXT;
            r_code <= 8'h00;
            r_bad  <= 1'b0;
        end else begin
            r_mode <= n_mode;
            r_code <= n_code;
            r_bad  <= n_bad;
        end
    end

    always_comb begin
        n_mode = r_mode;
        n_code = r_code;
        n_bad  = r_bad;
        if (accept) begin
            case (r_mode)
                MODE_ESC: begin
                    n_mode = MODE_TEXT;
                    if (i_byte == CH_LC_U) begin
                        n_code = 8'h00;
                        n_bad  = 1'b0;
                        if (!i_last) begin
                            n_mode = MODE_HEX0;
                        end
                    end
                end
                MODE_HEX0, MODE_HEX1, MODE_HEX2, MODE_HEX3: begin
                    if (hv_bad) begin
                        n_bad = 1'b1;
                    end else begin
                        n_code = code_upd;
                    end
                    if (r_mode == MODE_HEX3 || i_last) begin
                        n_mode = MODE_TEXT;
                    end else begin
                        n_mode = t_mode'(r_mode + 3'd1);
                    end
                end
                default: begin
                    if (i_byte == CH_BSLASH && !i_last) begin
                        n_mode = MODE_ESC;
                    end else begin
                        n_mode = MODE_TEXT;
                    end
                end
            endcase
        end
    end

    always_comb begin
        o_push      = 1'b0;
        o_cmd       = '0;
        o_cmd.last  = i_last;
        o_cmd.data  = i_byte;
        case (r_mode)
            MODE_ESC: begin
                o_push = accept;
                case (i_byte)
                    CH_BSLASH, CH_QUOTE: o_cmd.data = i_byte;
                    CH_LC_B:             o_cmd.data = CH_BS;
                    CH_LC_F:             o_cmd.data = CH_FF;
                    CH_LC_N:             o_cmd.data = CH_LF;
                    CH_LC_R:             o_cmd.data = CH_CR;
                    CH_LC_T:             o_cmd.data = CH_TAB;
                    CH_LC_U: begin
                        // truncated \u: error result only when the string ends here
                        o_push      = accept && i_last;
                        o_cmd.data  = 8'h00;
                        o_cmd.error = 1'b1;
                    end
                    default:             o_cmd.pair = 1'b1;
                endcase
            end
            MODE_HEX0, MODE_HEX1, MODE_HEX2, MODE_HEX3: begin
                if (r_mode == MODE_HEX3) begin
                    o_push = accept;
                    if (r_bad || hv_bad) begin
                        o_cmd.data  = 8'h00;
                        o_cmd.error = 1'b1;
                    end else begin
                        o_cmd.data = code_upd;
                    end
                end else begin
                    o_push      = accept && i_last;
                    o_cmd.data  = 8'h00;
                    o_cmd.error = 1'b1;
                end
            end
            default: begin
                o_push = accept && !(i_byte == CH_BSLASH && !i_last);
            end
        endcase
    end

endmodule

// File: rtl/jsu_fifo.sv
module jsu_fifo #(
    parameter int unsigned DEPTH = jsu_pkg::QDEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  jsu_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_not_full,
    output logic          o_not_empty,
    output jsu_pkg::t_cmd o_cmd
);
    import jsu_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_not_full  = (r_count != CNT_FULL);
    assign o_not_empty = (r_count != '0);
    assign do_push     = i_push && o_not_full;
    assign do_pop      = i_pop && o_not_empty;
    assign o_cmd       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: rtl/jsu_back.sv
module jsu_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  jsu_pkg::t_cmd i_q_cmd,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [7:0]    o_byte,
    output logic          o_last,
    output logic          o_error
);
    import jsu_pkg::*;

    t_cmd r_cmd;
    logic r_valid;
    logic r_second;
    logic first_of_pair;
    logic load;

    assign first_of_pair = r_cmd.pair && !r_second;
    // take the next command once the current one has given all its results
    assign load  = !r_valid || (i_ready && !first_of_pair);
    assign o_pop = load && i_q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else if (r_valid && i_ready && first_of_pair) begin
            r_second <= 1'b1;
        end else if (load) begin
            r_valid  <= i_q_valid;
            r_second <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cmd <= i_q_cmd;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = first_of_pair ? CH_BSLASH : r_cmd.data;
    assign o_last  = first_of_pair ? 1'b0 : r_cmd.last;
    assign o_error = r_cmd.error;

endmodule

// File: rtl/json_string_unescaper.sv
// JSON string unescaper: feed the escaped body of a JSON string one byte per
// item on s_axis (tlast on the final byte) and take the unescaped bytes on
// m_axis, tlast on the final result of the string. The input side takes one
// byte every cycle; each result goes through the command queue, then the
// output register. An unknown escape gives two results (the backslash, then
// the byte), which occupy the output in turn; the command queue of QDEPTH
// entries between the parser and the output stage absorbs that, and the input
// stalls only when the queue is full. A \u escape gives the low byte of its
// four hex digits; a bad digit or a string that ends inside the escape gives
// a result with tuser set and tdata zero; the whole string should be dropped.
module json_string_unescaper #(
    parameter int unsigned QDEPTH = jsu_pkg::QDEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tlast,   // in_last
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tlast,   // out_last
    output logic       m_axis_tuser    // [0] out_error
);
    import jsu_pkg::*;

    logic q_not_full, q_not_empty, push, pop;
    t_cmd push_cmd, head_cmd;

    jsu_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .i_byte   (s_axis_tdata),
        .i_last   (s_axis_tlast),
        .i_q_ready(q_not_full),
        .o_ready  (s_axis_tready),
        .o_push   (push),
        .o_cmd    (push_cmd)
    );

    jsu_fifo #(
        .DEPTH(QDEPTH)
    ) u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_cmd      (push_cmd),
        .i_pop      (pop),
        .o_not_full (q_not_full),
        .o_not_empty(q_not_empty),
        .o_cmd      (head_cmd)
    );

    jsu_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_valid(q_not_empty),
        .i_q_cmd  (head_cmd),
        .o_pop    (pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_byte   (m_axis_tdata),
        .o_last   (m_axis_tlast),
        .o_error  (m_axis_tuser)
    );

endmodule

// File: rtl/jsu_checker.sv
module jsu_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast,
    input logic       m_axis_tuser
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 8'h00)
        else $error("error result carries data");

    // a full queue means the output stage is already loaded
    a_stall_has_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with nothing to send");

endmodule

bind json_string_unescaper jsu_checker u_jsu_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
);

// File: dv/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import jsu_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned DRAIN_CYCLES = 8;

    typedef struct {
        logic [7:0] data;
        logic       last;
        logic       error;
    } unesc_t;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;   // [7:0] in_byte
    logic       s_axis_tlast = 1'b0;    // in_last
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // [7:0] out_byte
    logic       m_axis_tlast;           // out_last
    logic       m_axis_tuser;           // [0] out_error

    // Parser state mirror
    t_mode      esc_mode = MODE_TEXT;
    logic [7:0] code_byte = 8'h00;
    logic       code_bad = 1'b0;

    unesc_t      unescaped_q[$];
    logic [8:0]  escaped_q[$];          // {last, byte}
    unesc_t      oldest;
    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;
    int unsigned src_idle_pct = 0;
    int unsigned sink_stall_pct = 0;
    int unsigned hold_count = 0;
    bit          hold_request = 1'b0;

    logic [7:0] simple_escapes[7] = '{CH_BSLASH, CH_QUOTE, CH_LC_B, CH_LC_F,
                                      CH_LC_N, CH_LC_R, CH_LC_T};

    json_string_unescaper dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Returns 0..15 for a hex digit, 16 for anything else
    function automatic int unsigned digit_of(input logic [7:0] c);
        if (c >= "0" && c <= "9") return c - "0";
        if (c >= "a" && c <= "f") return c - "a" + 10;
        if (c >= "A" && c <= "F") return c - "A" + 10;
        return 16;
    endfunction

    function automatic void push_result(input logic [7:0] d, input logic l, input logic e);
        unesc_t r;
        r.data = d;
        r.last = l;
        r.error = e;
        unescaped_q.push_back(r);
    endfunction

    function automatic void unescape_byte(input logic [7:0] c, input logic l);
        int unsigned d;
        case (esc_mode)
            MODE_ESC: begin
                esc_mode = MODE_TEXT;
                case (c)
                    CH_BSLASH: push_result(CH_BSLASH, l, 1'b0);
                    CH_QUOTE:  push_result(CH_QUOTE, l, 1'b0);
                    CH_LC_B:   push_result(CH_BS, l, 1'b0);
                    CH_LC_F:   push_result(CH_FF, l, 1'b0);
                    CH_LC_N:   push_result(CH_LF, l, 1'b0);
                    CH_LC_R:   push_result(CH_CR, l, 1'b0);
                    CH_LC_T:   push_result(CH_TAB, l, 1'b0);
                    CH_LC_U: begin
                        code_byte = 8'h00;
                        code_bad = 1'b0;
                        if (l) push_result(8'h00, 1'b1, 1'b1);
                        else esc_mode = MODE_HEX0;
                    end
                    default: begin
                        push_result(CH_BSLASH, 1'b0, 1'b0);
                        push_result(c, l, 1'b0);
                    end
                endcase
            end
            MODE_HEX0, MODE_HEX1, MODE_HEX2, MODE_HEX3: begin
                d = digit_of(c);
                if (d > 15) code_bad = 1'b1;
                else code_byte = {code_byte[3:0], d[3:0]};
                if (esc_mode == MODE_HEX3) begin
                    esc_mode = MODE_TEXT;
                    if (code_bad) push_result(8'h00, l, 1'b1);
                    else push_result(code_byte, l, 1'b0);
                end else if (l) begin
                    // string ended inside the escape
                    esc_mode = MODE_TEXT;
                    push_result(8'h00, 1'b1, 1'b1);
                end else begin
                    esc_mode = t_mode'(esc_mode + 3'd1);
                end
            end
            default: begin
                esc_mode = MODE_TEXT;
                if (c == CH_BSLASH && !l) esc_mode = MODE_ESC;
                else push_result(c, l, 1'b0);
            end
        endcase
    endfunction

    // Receiver: random stalls, or a long hold when requested
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_count = HOLD_CYCLES;
            end
            if (hold_count != 0) begin
                hold_count = hold_count - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
            if (unescaped_q.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected result data=%h last=%b error=%b", $time,
                         m_axis_tdata, m_axis_tlast, m_axis_tuser);
            end else begin
                oldest = unescaped_q.pop_front();
                if (m_axis_tdata !== oldest.data || m_axis_tlast !== oldest.last ||
                        m_axis_tuser !== oldest.error) begin
                    fail_count++;
                    $display("%0t: mismatch expected data=%h last=%b error=%b, got data=%h last=%b error=%b",
                             $time, oldest.data, oldest.last, oldest.error,
                             m_axis_tdata, m_axis_tlast, m_axis_tuser);
                end
            end
        end
    end

    task automatic send_item(input logic [7:0] b, input logic l);
        @(negedge i_clk);
        if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(99) < src_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tlast <= l;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        unescape_byte(b, l);
    endtask

    task automatic send_queue(inout int unsigned sent);
        while (escaped_q.size() != 0) begin
            send_item(escaped_q[0][7:0], escaped_q[0][8]);
            void'(escaped_q.pop_front());
            sent++;
        end
    endtask

    task automatic stop_sending();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic wait_drain();
        while (unescaped_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic void push_byte(input logic [7:0] b);
        escaped_q.push_back({1'b0, b});
    endfunction

    function automatic logic [7:0] hex_char(input int unsigned v, input bit upper);
        if (v < 10) return 8'("0" + v);
        return upper ? 8'("A" + v - 10) : 8'("a" + v - 10);
    endfunction

    function automatic void push_hex_digits(input int unsigned n);
        repeat (n) push_byte(hex_char($urandom_range(15), $urandom_range(1)));
    endfunction

    // One string: mostly well-formed escapes with random content, some noise
    function automatic void build_string();
        int unsigned n_tok;
        int unsigned kind;
        int unsigned bad_pos;
        logic [7:0]  b;
        if ($urandom_range(99) < 12) begin
            repeat ($urandom_range(1, 8)) escaped_q.push_back({($urandom_range(7) == 0),
                                                               8'($urandom_range(255))});
        end else begin
            n_tok = $urandom_range(1, 10);
            repeat (n_tok) begin
                kind = $urandom_range(99);
                if (kind < 40) begin
                    push_byte(8'($urandom_range(255)));
                end else if (kind < 60) begin
                    push_byte(CH_BSLASH);
                    push_byte(simple_escapes[$urandom_range(6)]);
                end else if (kind < 78) begin
                    push_byte(CH_BSLASH);
                    push_byte(CH_LC_U);
                    push_hex_digits(4);
                end else if (kind < 86) begin
                    // one bad digit among the four
                    push_byte(CH_BSLASH);
                    push_byte(CH_LC_U);
                    bad_pos = $urandom_range(3);
                    for (int i = 0; i < 4; i++) begin
                        if (i == bad_pos) begin
                            do b = 8'($urandom_range(255)); while (digit_of(b) < 16);
                            push_byte(b);
                        end else begin
                            push_hex_digits(1);
                        end
                    end
                end else begin
                    push_byte(CH_BSLASH);
                    do b = 8'($urandom_range(255));
                    while (b == CH_LC_U || b inside {simple_escapes});
                    push_byte(b);
                end
            end
            kind = $urandom_range(99);
            if (kind < 6) begin
                push_byte(CH_BSLASH);
            end else if (kind < 14) begin
                push_byte(CH_BSLASH);
                push_byte(CH_LC_U);
                push_hex_digits($urandom_range(3));
            end
        end
        escaped_q[escaped_q.size() - 1][8] = 1'b1;
    endfunction

    task automatic test_directed();
        int unsigned sent;
        sent = 0;
        push_byte(8'h00);
        foreach (simple_escapes[i]) begin
            push_byte(CH_BSLASH);
            push_byte(simple_escapes[i]);
        end
        push_byte(CH_BSLASH);
        push_byte(CH_LC_U);
        push_byte("F");
        push_byte("f");
        push_byte("a");
        push_byte("9");
        // unknown escape closing the string, then a backslash as the last byte
        push_byte(CH_BSLASH);
        escaped_q.push_back({1'b1, 8'hFF});
        escaped_q.push_back({1'b1, CH_BSLASH});
        send_queue(sent);
        stop_sending();
        wait_drain();
    endtask

    task automatic test_random(input int unsigned n_items, input int unsigned src_pct,
                               input int unsigned sink_pct);
        int unsigned sent;
        sent = 0;
        src_idle_pct = src_pct;
        sink_stall_pct = sink_pct;
        while (sent < n_items) begin
            build_string();
            send_queue(sent);
        end
        stop_sending();
        wait_drain();
    endtask

    task automatic test_backpressure();
        int unsigned sent;
        sent = 0;
        src_idle_pct = 0;
        sink_stall_pct = 0;
        hold_request = 1'b1;
        while (sent < 80) begin
            build_string();
            send_queue(sent);
        end
        stop_sending();
        wait_drain();
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random(570, 26, 53);
        test_random(570, 53, 26);
        test_backpressure();
        test_random(570, 0, 0);
        if (fail_count == 0 && unescaped_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
